FILE: sv/life_cell_stencil_unit_assert.svh
// Assertion macros for the life cell stencil unit.
// Used by the top level; needs the clock and reset ports in scope.
`ifndef LIFE_CELL_STENCIL_UNIT_ASSERT_SVH
`define LIFE_CELL_STENCIL_UNIT_ASSERT_SVH

// Same-cycle implication, checked while out of reset
`define LCS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked while out of reset
`define LCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/lcs_pkg.sv
// Shared constants, register codes and the B3/S23 rule for the life cell stencil.
// No dependencies.
package lcs_pkg;

   // configuration port
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd1;
   localparam logic [CSR_DATA_W-1:0] GRID_DIM_RESET = 7'd6;

   // grid size limits
   localparam int DEF_MAX_COLS = 64;
   localparam int DEF_MAX_ROWS = 64;

   // width of the row and column fields of a response
   localparam int OUT_POS_W = 6;

   // life thresholds
   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   // Window is column-major: bits 0..2 oldest column, center cell is bit 4.
   function automatic logic life_next(input logic [8:0] win);
      logic [3:0] count;
      count = 4'd0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4) count = count + {3'b000, win[k]};
      end
      return (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && win[4]);
   endfunction

endpackage

FILE: sv/life_cell_stencil_unit.sv
// Top level of the life cell stencil: line store memory, 3x3 window, response register.
// Depends on lcs_pkg and life_cell_stencil_unit_assert.svh.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   req     | in        | req_valid/req_stall | cell_alive, frame_start, is_padding
//   rsp     | out       | rsp_valid/rsp_stall | next_alive, out_row, out_col, last_of_gen.
//   csr     | in        | csr_wr_en           | csr_index, csr_wdata
//
// One request per clock unless stalled. A request reads the line store memory when
// accepted, then updates the store and window; a response is visible the cycle after that
// update. A cell is reported on the request grid_cols+1 positions after it, so a
// generation needs grid_cols+1 padding requests. Reset clears one valid bit per column;
// no clearing pass. A stalled response holds the update stage, which then stalls requests.
module life_cell_stencil_unit
   #(parameter int MAX_COLS = lcs_pkg::DEF_MAX_COLS,
     parameter int MAX_ROWS = lcs_pkg::DEF_MAX_ROWS)
   (input  logic                              clock,
    input  logic                              reset,
    // request channel
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              req_cell_alive,
    input  logic                              req_frame_start,
    input  logic                              req_is_padding,
    // response channel
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic                              rsp_next_alive,
    output logic [lcs_pkg::OUT_POS_W-1:0]     rsp_out_row,
    output logic [lcs_pkg::OUT_POS_W-1:0]     rsp_out_col,
    output logic                              rsp_last_of_generation,
    // configuration
    input  logic                              csr_wr_en,
    input  logic [lcs_pkg::CSR_IDX_W-1:0]     csr_index,
    input  logic [lcs_pkg::CSR_DATA_W-1:0]    csr_wdata);

   import lcs_pkg::*;

   `include "life_cell_stencil_unit_assert.svh"

   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int COLS_W = $clog2(MAX_COLS + 1);
   localparam int ROWS_W = $clog2(MAX_ROWS + 1);
   localparam int ROW_W  = $clog2(MAX_ROWS + 3);
   localparam int CC_W   = (COLS_W > CSR_DATA_W) ? COLS_W : CSR_DATA_W;
   localparam int RC_W   = (ROWS_W > CSR_DATA_W) ? ROWS_W : CSR_DATA_W;
   localparam int ER_W   = (ROW_W > OUT_POS_W) ? ROW_W : OUT_POS_W;
   localparam int EC_W   = (COLS_W > OUT_POS_W) ? COLS_W : OUT_POS_W;
   localparam logic [ROW_W-1:0] ROW_STOP = ROW_W'(MAX_ROWS + 2);

   // configuration registers
   logic [CSR_DATA_W-1:0] grid_cols_ff, grid_rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_DIM_RESET;
         grid_rows_ff <= GRID_DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_GRID_COLS: grid_cols_ff <= csr_wdata;
            CSR_GRID_ROWS: grid_rows_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamp dimensions to 1..MAX
   logic [CC_W-1:0]   cols_ext;
   logic [RC_W-1:0]   rows_ext;
   logic [COLS_W-1:0] cols;
   logic [ROWS_W-1:0] rows;

   always_comb begin
      cols_ext = CC_W'(grid_cols_ff);
      rows_ext = RC_W'(grid_rows_ff);
      if (cols_ext == '0) cols_ext = CC_W'(1);
      else if (cols_ext > CC_W'(MAX_COLS)) cols_ext = CC_W'(MAX_COLS);
      if (rows_ext == '0) rows_ext = RC_W'(1);
      else if (rows_ext > RC_W'(MAX_ROWS)) rows_ext = RC_W'(MAX_ROWS);
      cols = COLS_W'(cols_ext);
      rows = ROWS_W'(rows_ext);
   end

   // handshake
   logic s1_valid_ff, s1_advance, req_accept;
   logic rsp_valid_ff;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   // raster position of the incoming request
   logic [ROW_W-1:0]  in_row_ff, in_row_in, r0;
   logic [COL_W-1:0]  in_col_ff, in_col_in, c0;
   logic [COLS_W-1:0] c0_inc;
   logic              bot0;

   always_comb begin
      r0 = req_frame_start ? '0 : in_row_ff;
      c0 = req_frame_start ? '0 : in_col_ff;
      // fold a column left beyond a shrunken grid
      if (COLS_W'(c0) >= cols) begin
         c0 = '0;
         if (r0 < ROW_STOP) r0 = r0 + ROW_W'(1);
      end
      bot0   = req_cell_alive && !req_is_padding && (r0 < ROW_W'(rows));
      c0_inc = COLS_W'(c0) + COLS_W'(1);
      if (c0_inc >= cols) begin
         in_col_in = '0;
         in_row_in = (r0 < ROW_STOP) ? r0 + ROW_W'(1) : r0;
      end else begin
         in_col_in = COL_W'(c0_inc);
         in_row_in = r0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (req_accept) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
      end
   end

   // update stage item
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             bot;
   } s1_item_type;

   s1_item_type s1_ff;
   logic        s1_fwd_ff, s1_fwd_in;
   logic [1:0]  s1_fwd_data_ff;
   logic [1:0]  wr_data;

   // back-to-back request on the column being written reads stale memory data
   assign s1_fwd_in = s1_advance && (s1_ff.col == c0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff          <= '{row: r0, col: c0, bot: bot0};
         s1_fwd_ff      <= s1_fwd_in;
         s1_fwd_data_ff <= wr_data;
      end
   end

   // line store memory: bit 1 upper line, bit 0 middle line
   logic [1:0] line_mem [MAX_COLS];
   logic       line_vld_ff [MAX_COLS];
   logic [1:0] rd_ff;
   logic       rd_vld_ff;

   always_ff @(posedge clock) begin
      if (s1_advance) line_mem[s1_ff.col] <= wr_data;
      if (req_accept) rd_ff <= line_mem[c0];
   end

   // per-column valid bits give the all-dead reset contents
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COLS; i++) line_vld_ff[i] <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (s1_advance) line_vld_ff[s1_ff.col] <= 1'b1;
         if (req_accept) rd_vld_ff <= line_vld_ff[c0];
      end
   end

   // read-modify-write of the column and window shift
   logic [1:0]        line;
   logic              top, mid;
   logic [2:0]        newcol;
   logic [8:0]        win, window_in, window_ff;
   logic              emit;
   logic [ER_W-1:0]   er;
   logic [EC_W-1:0]   ec;

   always_comb begin
      line = s1_fwd_ff ? s1_fwd_data_ff : (rd_vld_ff ? rd_ff : 2'b00);
      wr_data = {line[0], s1_ff.bot};
      top = (s1_ff.row >= ROW_W'(2)) && line[1];
      mid = (s1_ff.row >= ROW_W'(1)) && line[0];
      newcol = {s1_ff.bot, mid, top};
      er = '0;
      ec = '0;
      if (s1_ff.col == '0) begin
         // previous row's last column closes against a dead column
         win       = {3'b000, window_ff[8:3]};
         window_in = {newcol, 6'b000000};
         emit      = (s1_ff.row >= ROW_W'(2)) &&
                     ((s1_ff.row - ROW_W'(2)) < ROW_W'(rows));
         er        = ER_W'(s1_ff.row - ROW_W'(2));
         ec        = EC_W'(cols - COLS_W'(1));
      end else begin
         win       = {newcol, window_ff[8:3]};
         window_in = win;
         emit      = (s1_ff.row >= ROW_W'(1)) &&
                     ((s1_ff.row - ROW_W'(1)) < ROW_W'(rows));
         er        = ER_W'(s1_ff.row - ROW_W'(1));
         ec        = EC_W'(s1_ff.col - COL_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else if (s1_advance) begin
         window_ff <= window_in;
      end
   end

   // response register
   logic                 next_alive_ff, last_ff;
   logic [OUT_POS_W-1:0] out_row_ff, out_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= emit;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && emit) begin
         next_alive_ff <= life_next(win);
         out_row_ff    <= er[OUT_POS_W-1:0];
         out_col_ff    <= ec[OUT_POS_W-1:0];
         last_ff       <= (er == ER_W'(rows - ROWS_W'(1))) &&
                          (ec == EC_W'(cols - COLS_W'(1)));
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_next_alive         = next_alive_ff;
   assign rsp_out_row            = out_row_ff;
   assign rsp_out_col            = out_col_ff;
   assign rsp_last_of_generation = last_ff;

   // checks
   `LCS_ASSERT_NOW(a_stall_only_when_busy, req_stall, s1_valid_ff,
      "request stalled with empty update stage")
   `LCS_ASSERT_NEXT(a_held_item_stays, s1_valid_ff && !s1_advance,
      s1_valid_ff && $stable(s1_ff), "held update item changed")
   `LCS_ASSERT_NEXT(a_same_column_forwards, req_accept && s1_advance && (s1_ff.col == c0),
      s1_fwd_ff, "write to same column not forwarded")
   `LCS_ASSERT_NOW(a_last_is_last_column, rsp_valid_ff && last_ff,
      out_col_ff == OUT_POS_W'(cols - COLS_W'(1)), "last cell not in last column")

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// Testbench for life_cell_stencil_unit: streams generations of cells and checks each response
// against a cycle-free model of the B3/S23 stencil kept here. Depends on lcs_pkg and the RTL.
module tb;
   import lcs_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 500000;
   localparam int unsigned SETTLE       = 8;
   localparam int unsigned RANDOM_ITEMS = 1800;

   typedef struct packed {
      logic alive;
      logic frame_start;
      logic padding;
   } cell_req_type;

   typedef struct packed {
      logic                 alive;
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] col;
      logic                 last;
   } cell_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cell_alive = 1'b0;
   logic req_frame_start = 1'b0;
   logic req_is_padding = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_next_alive;
   logic [OUT_POS_W-1:0] rsp_out_row;
   logic [OUT_POS_W-1:0] rsp_out_col;
   logic                 rsp_last_of_generation;

   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_GRID_COLS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // requests waiting to be sent, responses waiting to arrive
   cell_req_type cell_stream[$];
   cell_rsp_type next_gen_cells[$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count;
   int unsigned queued_count = 0;

   // stencil model state
   logic upper_store  [DEF_MAX_COLS];
   logic middle_store [DEF_MAX_COLS];
   logic [8:0] window = '0;
   int unsigned row_pos = 0;
   int unsigned col_pos = 0;
   logic [CSR_DATA_W-1:0] cfg_cols = GRID_DIM_RESET;
   logic [CSR_DATA_W-1:0] cfg_rows = GRID_DIM_RESET;

   // sender burst state
   int burst_left = 1;
   int gap_left   = 0;

   // receiver stall pattern state
   int       stall_mode = 0;
   int       mode_left  = 0;
   int unsigned stall_tick = 0;

   life_cell_stencil_unit DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_cell_alive         (req_cell_alive),
      .req_frame_start        (req_frame_start),
      .req_is_padding         (req_is_padding),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_next_alive         (rsp_next_alive),
      .rsp_out_row            (rsp_out_row),
      .rsp_out_col            (rsp_out_col),
      .rsp_last_of_generation (rsp_last_of_generation),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata));

   always #10 clock = ~clock;

   // register value as the block uses it: 0 reads as 1, large values saturate
   function automatic int unsigned eff_dim(input logic [CSR_DATA_W-1:0] raw,
                                           input int unsigned top);
      if (raw == 0) return 1;
      if (raw > top) return top;
      return 32'(raw);
   endfunction

   // Advance the stencil model by one accepted request; queue the cell it completes, if any.
   task automatic step_life_model(input cell_req_type item);
      int unsigned cols, rows, r, c, er, ec, count;
      logic bot, top, mid, emit;
      logic [2:0] newcol;
      logic [8:0] win;
      cell_rsp_type res;
      cols = eff_dim(cfg_cols, DEF_MAX_COLS);
      rows = eff_dim(cfg_rows, DEF_MAX_ROWS);
      er = 0;
      ec = 0;
      emit = 1'b0;
      if (item.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      // fold a column left over from a wider grid
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos = (row_pos < DEF_MAX_ROWS + 2) ? row_pos + 1 : row_pos;
      end
      r = row_pos;
      c = col_pos;
      bot = item.alive && !item.padding && (r < rows);
      top = (r >= 2) ? upper_store[c] : 1'b0;
      mid = (r >= 1) ? middle_store[c] : 1'b0;
      upper_store[c] = middle_store[c];
      middle_store[c] = bot;
      newcol = {bot, mid, top};
      if (c == 0) begin
         // previous row's last cell sees a dead column on its right
         win = {3'b000, window[8:3]};
         if (r >= 2 && r - 2 < rows) begin
            emit = 1'b1;
            er = r - 2;
            ec = cols - 1;
         end
         window = {newcol, 6'b000000};
      end else begin
         win = {newcol, window[8:3]};
         window = win;
         if (r >= 1 && r - 1 < rows) begin
            emit = 1'b1;
            er = r - 1;
            ec = c - 1;
         end
      end
      col_pos = c + 1;
      if (col_pos >= cols) begin
         col_pos = 0;
         row_pos = (row_pos < DEF_MAX_ROWS + 2) ? row_pos + 1 : row_pos;
      end
      if (emit) begin
         count = $countones(win) - win[4];
         res.alive = (count == BIRTH_COUNT) || ((count == SURVIVE_COUNT) && win[4]);
         res.row = er[OUT_POS_W-1:0];
         res.col = ec[OUT_POS_W-1:0];
         res.last = (er == rows - 1) && (ec == cols - 1);
         next_gen_cells.push_back(res);
      end
   endtask

   // Driver: bursts of requests with random gaps; model steps on each accepted request.
   always @(posedge clock) begin
      cell_req_type head;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            step_life_model({req_cell_alive, req_frame_start, req_is_padding});
         if (!req_valid || !req_stall) begin
            if (gap_left > 0 || cell_stream.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               head = cell_stream.pop_front();
               req_valid <= 1'b1;
               req_cell_alive <= head.alive;
               req_frame_start <= head.frame_start;
               req_is_padding <= head.padding;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // Receiver stall: modes of random length - none, light, heavy, periodic
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_tick++;
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= ($urandom_range(0, 9) < 6);
            end
            default: begin
               rsp_stall <= (stall_tick % 7 < 3);
            end
         endcase
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   // Monitor: every accepted response against the oldest expected cell
   always @(posedge clock) begin
      cell_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (next_gen_cells.size() == 0) begin
            mismatch_count++;
            $display("%0t: expected no response, got alive %0b row %0d col %0d last %0b",
                     $time, rsp_next_alive, rsp_out_row, rsp_out_col,
                     rsp_last_of_generation);
         end else begin
            want = next_gen_cells.pop_front();
            check_field("next_alive", 32'(want.alive), 32'(rsp_next_alive));
            check_field("out_row", 32'(want.row), 32'(rsp_out_row));
            check_field("out_col", 32'(want.col), 32'(rsp_out_col));
            check_field("last_of_generation", 32'(want.last),
                        32'(rsp_last_of_generation));
         end
      end
   end

   task automatic push_req(input logic alive, input logic fs, input logic pad);
      cell_req_type item;
      item.alive = alive;
      item.frame_start = fs;
      item.padding = pad;
      cell_stream.push_back(item);
      queued_count++;
   endtask

   // Wait until every request is sent and every response is in, then let the pipe settle.
   task automatic wait_drained();
      while (cell_stream.size() != 0 || req_valid || next_gen_cells.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Both registers, written back to back while idle
   task automatic write_grid(input logic [CSR_DATA_W-1:0] cols_raw,
                             input logic [CSR_DATA_W-1:0] rows_raw);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= cols_raw;
      @(posedge clock);
      cfg_cols = cols_raw;
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows_raw;
      @(posedge clock);
      cfg_rows = rows_raw;
      csr_wr_en <= 1'b0;
   endtask

   // One generation: real cells then flush padding; may be cut short or followed by a tail.
   task automatic queue_frame(input int unsigned cols, input int unsigned rows,
                              input int unsigned density, input int cut_at,
                              input int unsigned tail);
      int unsigned total, cells;
      logic real_cell, fs, pad, alive;
      cells = rows * cols;
      total = cells + cols + 1;
      for (int i = 0; i < total; i++) begin
         if (cut_at >= 0 && i == cut_at) break;
         real_cell = (i < cells);
         fs = (i == 0) || ($urandom_range(0, 255) == 0);
         alive = real_cell ? ($urandom_range(0, 7) < density) : 1'($urandom_range(0, 1));
         pad = !real_cell || ($urandom_range(0, 63) == 0);
         push_req(alive, fs, pad);
      end
      repeat (tail) push_req(1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
   endtask

   // Unstructured requests; frame_start once in fs_odds (never when fs_odds is 0)
   task automatic queue_noise(input int unsigned n, input int unsigned fs_odds);
      repeat (n)
         push_req(1'($urandom_range(0, 1)),
                  (fs_odds != 0) && ($urandom_range(1, fs_odds) == 1),
                  1'($urandom_range(0, 1)));
   endtask

   // Timeout
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
   end

   // Stimulus and verdict
   initial begin
      logic [CSR_DATA_W-1:0] cols_raw, rows_raw;
      int unsigned cols, rows, sel, ngen;
      for (int i = 0; i < DEF_MAX_COLS; i++) begin
         upper_store[i] = 1'b0;
         middle_store[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // zero registers read as a 1x1 grid; restart mid-frame, live padding,
      // live non-padding cells past the last row
      write_grid(7'd0, 7'd0);
      push_req(1'b1, 1'b1, 1'b0);
      push_req(1'b0, 1'b0, 1'b1);
      push_req(1'b1, 1'b1, 1'b0);
      push_req(1'b1, 1'b0, 1'b1);
      push_req(1'b0, 1'b0, 1'b1);
      push_req(1'b1, 1'b0, 1'b0);
      wait_drained();

      // vertical blinker on 3x3: births with three, survival with two,
      // dead cell with two stays dead, live padding ignored
      write_grid(7'd3, 7'd3);
      for (int i = 0; i < 9; i++) push_req(i % 3 == 1, i == 0, 1'b0);
      push_req(1'b1, 1'b0, 1'b1);
      repeat (3) push_req(1'b0, 1'b0, 1'b1);
      wait_drained();

      // random phases: mostly small grids, a few at the size limits
      queued_count = 0;
      while (queued_count < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            case ($urandom_range(0, 3))
               0: cols_raw = 7'd64;
               1: cols_raw = 7'd65;
               2: cols_raw = 7'd127;
               default: cols_raw = 7'($urandom_range(64, 127));
            endcase
            rows_raw = 7'($urandom_range(0, 4));
         end else if (sel == 1) begin
            cols_raw = 7'($urandom_range(0, 3));
            case ($urandom_range(0, 2))
               0: rows_raw = 7'd64;
               1: rows_raw = 7'd127;
               default: rows_raw = 7'($urandom_range(64, 127));
            endcase
         end else begin
            cols_raw = 7'($urandom_range(0, 10));
            rows_raw = 7'($urandom_range(0, 10));
         end
         write_grid(cols_raw, rows_raw);
         cols = eff_dim(cols_raw, DEF_MAX_COLS);
         rows = eff_dim(rows_raw, DEF_MAX_ROWS);
         // no frame_start first, so a column left beyond a shrunken grid folds
         if ($urandom_range(0, 2) == 0) queue_noise($urandom_range(1, 4), 0);
         ngen = $urandom_range(1, 3);
         repeat (ngen) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
               queue_frame(cols, rows, $urandom_range(0, 8), -1,
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 80) : 0);
            else if (sel < 9)
               queue_frame(cols, rows, $urandom_range(0, 8),
                           $urandom_range(0, rows * cols + cols), 0);
            else
               queue_noise($urandom_range(1, 20), 8);
         end
         wait_drained();
      end

      if (next_gen_cells.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d expected responses never arrived", $time, next_gen_cells.size());
      end
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
